// File: hw/rtl/plic_pkg.sv
// plic_pkg: shared constants, codes and state type of the interrupt controller
// no dependencies; used by the channel interfaces and the top level
package plic_pkg;

  localparam int NUM_SOURCES_DEF   = 64;
  localparam int NUM_CONTEXTS_DEF  = 2;
  localparam int PRIORITY_BITS_DEF = 3;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 26;
  localparam int DATA_W   = 32;
  localparam int SRC_ID_W = 6;
  localparam int LINES_W  = 2;

  // register map
  localparam logic [ADDR_W-1:0] ENABLE_BASE  = 26'h000_2000;
  localparam logic [ADDR_W-1:0] CONTEXT_BASE = 26'h020_0000;
  localparam int ENABLE_STRIDE  = 32'h80;
  localparam int CONTEXT_STRIDE = 32'h1000;
  localparam logic [11:0] THRESHOLD_OFFSET = 12'h000;
  localparam logic [11:0] CLAIM_OFFSET     = 12'h004;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_REQUEST = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REQUEST,
    OP_PRIO,
    OP_ENABLE,
    OP_THRESH,
    OP_CLAIM
  } op_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/plic_item_if.sv
// plic_item_if: request channel of the interrupt controller (bus access or source request)
// depends on plic_pkg for field widths
interface plic_item_if;
  logic                          valid;
  logic                          ready;
  logic [plic_pkg::ACTION_W-1:0] action;
  logic [plic_pkg::ADDR_W-1:0]   address;
  logic [plic_pkg::DATA_W-1:0]   write_data;
  logic [plic_pkg::SRC_ID_W-1:0] source_id;

  modport source (output valid, action, address, write_data, source_id, input ready);
  modport sink (input valid, action, address, write_data, source_id, output ready);
endinterface

// File: hw/rtl/plic_result_if.sv
// plic_result_if: result channel of the interrupt controller
// depends on plic_pkg for field widths
interface plic_result_if;
  logic                         valid;
  logic                         ready;
  logic [plic_pkg::DATA_W-1:0]  read_data;
  logic [plic_pkg::LINES_W-1:0] irq_lines;

  modport source (output valid, read_data, irq_lines, input ready);
  modport sink (input valid, read_data, irq_lines, output ready);
endinterface

// File: hw/rtl/platform_interrupt_controller_unit.sv
// platform_interrupt_controller_unit: interrupt controller behind a word-addressed register map
// depends on plic_pkg, plic_item_if and plic_result_if
// every item ends with a scan of all sources for the interrupt lines, a claim read with a claim
//   scan first; one source is compared per cycle by a single scan unit over the priority memory
// throughput: one item at a time; the next item is taken while the last result waits
// reset: a clearing pass zeroes the priority and enable memories, during which no item is accepted
module platform_interrupt_controller_unit #(
  parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  plic_item_if.sink     req,
  plic_result_if.source rsp
);

  localparam int AW        = plic_pkg::ADDR_W;
  localparam int DW        = plic_pkg::DATA_W;
  localparam int LW        = plic_pkg::LINES_W;
  localparam int P         = PRIORITY_BITS;
  localparam int ID_W      = $clog2(NUM_SOURCES);
  localparam int SRC_WORDS = (NUM_SOURCES + 31) / 32;
  localparam int WORD_W    = (SRC_WORDS > 1) ? $clog2(SRC_WORDS) : 1;
  localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int EN_AW     = CTX_W + WORD_W;
  localparam int EN_DEPTH  = 1 << EN_AW;
  localparam int CLR_LEN   = (NUM_SOURCES > EN_DEPTH) ? NUM_SOURCES : EN_DEPTH;
  localparam int CLR_W     = $clog2(CLR_LEN);
  localparam int SCAN_W    = $clog2(NUM_SOURCES + 1);
  localparam int CTX_B     = (NUM_CONTEXTS > 1) ? 1 : 0;

  localparam logic [AW-1:0] PRIO_END = AW'(4 * NUM_SOURCES);
  localparam logic [AW-1:0] EN_END   =
    plic_pkg::ENABLE_BASE + AW'(NUM_CONTEXTS * plic_pkg::ENABLE_STRIDE);
  localparam logic [AW-1:0] CTX_END  =
    plic_pkg::CONTEXT_BASE + AW'(NUM_CONTEXTS * plic_pkg::CONTEXT_STRIDE);

  // valid enable bits of one word: source zero and ids past the last source stay clear
  function automatic logic [31:0] en_mask(input logic [WORD_W-1:0] w);
    logic [31:0] m;
    int          id;
    for (int i = 0; i < 32; i++) begin
      id   = int'(w) * 32 + i;
      m[i] = (id != 0) && (id < NUM_SOURCES);
    end
    return m;
  endfunction

  plic_pkg::state_t state, state_next;

  // memories
  logic [P-1:0]  prio_mem [NUM_SOURCES];
  logic [31:0]   en_mem [EN_DEPTH];
  logic [P-1:0]  prio_rd;
  logic [31:0]   en_rd_a, en_rd_b;
  logic          prio_we, en_we;
  logic [ID_W-1:0]  prio_wa, prio_ra;
  logic [P-1:0]     prio_wd;
  logic [EN_AW-1:0] en_wa, en_ra_a, en_ra_b;
  logic [31:0]      en_wd;

  // control and state registers
  logic [CLR_W-1:0]       clr_idx;
  logic [NUM_SOURCES-1:0] pending;
  logic [NUM_SOURCES-1:0] claimed;
  logic [P-1:0]           thresh [NUM_CONTEXTS];
  logic                   out_valid;

  // latched item
  plic_pkg::op_kind_t op_kind;
  logic               op_write;
  logic [CTX_W-1:0]   op_ctx;
  logic [ID_W-1:0]    op_idx;
  logic [DW-1:0]      op_wdata;
  logic [plic_pkg::SRC_ID_W-1:0] op_src;
  logic [DW-1:0]      rdata;
  logic [LW-1:0]      lines;
  logic [DW-1:0]      out_data;
  logic [LW-1:0]      out_lines;

  // scan unit
  logic [SCAN_W-1:0] scan_idx;
  logic              scan_vld;
  logic [ID_W-1:0]   scan_id_q;
  logic              scan_claim;
  logic [ID_W-1:0]   best_a_id, best_b_id, best_a_id_next, best_b_id_next;
  logic [P-1:0]      best_a_prio, best_b_prio, best_a_prio_next, best_b_prio_next;
  logic              scan_issue, scan_done, scan_start, start_claim;
  logic [CTX_W-1:0]  lane_a_ctx, start_ctx;
  logic              hit_a, hit_b;

  // decode of the incoming item
  plic_pkg::op_kind_t dec_kind;
  logic [CTX_W-1:0]   dec_ctx;
  logic [ID_W-1:0]    dec_idx;
  logic [AW-1:0]      addr_w, en_rel, ctx_rel;

  // item checks
  logic            src_ok;
  logic [ID_W-1:0] src_id;
  logic            cmp_ok;
  logic [ID_W-1:0] cmp_id;
  logic            load_out;

  always_comb begin
    addr_w   = {req.address[AW-1:2], 2'b00};
    en_rel   = addr_w - plic_pkg::ENABLE_BASE;
    ctx_rel  = addr_w - plic_pkg::CONTEXT_BASE;
    dec_kind = plic_pkg::OP_NONE;
    dec_ctx  = '0;
    dec_idx  = '0;
    if (req.action == plic_pkg::ACT_REQUEST) begin
      dec_kind = plic_pkg::OP_REQUEST;
    end else if (req.action == plic_pkg::ACT_READ || req.action == plic_pkg::ACT_WRITE) begin
      if (addr_w < PRIO_END) begin
        dec_idx = addr_w[ID_W+1:2];
        if (dec_idx != '0) begin
          dec_kind = plic_pkg::OP_PRIO;
        end
      end else if (addr_w >= plic_pkg::ENABLE_BASE && addr_w < EN_END) begin
        dec_ctx = en_rel[7 +: CTX_W];
        dec_idx = ID_W'(en_rel[6:2]);
        if (int'(en_rel[6:2]) < SRC_WORDS) begin
          dec_kind = plic_pkg::OP_ENABLE;
        end
      end else if (addr_w >= plic_pkg::CONTEXT_BASE && addr_w < CTX_END) begin
        dec_ctx = ctx_rel[12 +: CTX_W];
        if (ctx_rel[11:0] == plic_pkg::THRESHOLD_OFFSET) begin
          dec_kind = plic_pkg::OP_THRESH;
        end else if (ctx_rel[11:0] == plic_pkg::CLAIM_OFFSET) begin
          dec_kind = plic_pkg::OP_CLAIM;
        end
      end
    end
  end

  always_comb begin
    src_ok = (op_src != '0) && (int'(op_src) < NUM_SOURCES);
    src_id = ID_W'(op_src);
    cmp_ok = (op_wdata != '0) && (op_wdata < DW'(NUM_SOURCES));
    cmp_id = ID_W'(op_wdata);
  end

  // scan compare stage: one source per cycle for up to two contexts
  always_comb begin
    scan_issue  = SCAN_W'(NUM_SOURCES) > scan_idx;
    scan_done   = (state == plic_pkg::S_SCAN) && (scan_idx == SCAN_W'(NUM_SOURCES));
    lane_a_ctx  = scan_claim ? op_ctx : '0;
    start_claim = (state == plic_pkg::S_EXEC);
    start_ctx   = start_claim ? op_ctx : '0;
    scan_start  = ((state == plic_pkg::S_EXEC || state == plic_pkg::S_READ) &&
                   state_next == plic_pkg::S_SCAN) || (scan_done && scan_claim);

    hit_a = scan_vld && pending[scan_id_q] && en_rd_a[scan_id_q[4:0]] && (prio_rd > best_a_prio);
    hit_b = scan_vld && pending[scan_id_q] && en_rd_b[scan_id_q[4:0]] && (prio_rd > best_b_prio);
    best_a_id_next   = hit_a ? scan_id_q : best_a_id;
    best_a_prio_next = hit_a ? prio_rd : best_a_prio;
    best_b_id_next   = hit_b ? scan_id_q : best_b_id;
    best_b_prio_next = hit_b ? prio_rd : best_b_prio;
    load_out = (state == plic_pkg::S_DONE) && (!out_valid || rsp.ready);
  end

  // memory port control
  always_comb begin
    prio_we = 1'b0;
    prio_wa = op_idx;
    prio_wd = op_wdata[P-1:0];
    en_we   = 1'b0;
    en_wa   = {op_ctx, WORD_W'(op_idx)};
    en_wd   = op_wdata & en_mask(WORD_W'(op_idx));
    if (state == plic_pkg::S_CLEAR) begin
      prio_we = int'(clr_idx) < NUM_SOURCES;
      prio_wa = ID_W'(clr_idx);
      prio_wd = '0;
      en_we   = int'(clr_idx) < EN_DEPTH;
      en_wa   = EN_AW'(clr_idx);
      en_wd   = '0;
    end else if (state == plic_pkg::S_EXEC && op_write) begin
      prio_we = (op_kind == plic_pkg::OP_PRIO);
      en_we   = (op_kind == plic_pkg::OP_ENABLE);
    end

    if (state == plic_pkg::S_SCAN) begin
      prio_ra = ID_W'(scan_idx);
      en_ra_a = {lane_a_ctx, WORD_W'(scan_idx >> 5)};
    end else if (op_kind == plic_pkg::OP_CLAIM) begin
      prio_ra = op_idx;
      en_ra_a = {op_ctx, WORD_W'(op_wdata >> 5)};
    end else begin
      prio_ra = op_idx;
      en_ra_a = {op_ctx, WORD_W'(op_idx)};
    end
    en_ra_b = {CTX_W'(CTX_B), WORD_W'(scan_idx >> 5)};
  end

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[prio_wa] <= prio_wd;
    end
    prio_rd <= prio_mem[prio_ra];
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      en_mem[en_wa] <= en_wd;
    end
    en_rd_a <= en_mem[en_ra_a];
    en_rd_b <= en_mem[en_ra_b];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plic_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      plic_pkg::S_CLEAR: begin
        if (clr_idx == CLR_W'(CLR_LEN - 1)) begin
          state_next = plic_pkg::S_IDLE;
        end
      end
      plic_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = plic_pkg::S_EXEC;
        end
      end
      plic_pkg::S_EXEC: begin
        // a claim read goes straight to its scan
        if (op_kind == plic_pkg::OP_CLAIM && !op_write) begin
          state_next = plic_pkg::S_SCAN;
        end else begin
          state_next = plic_pkg::S_READ;
        end
      end
      plic_pkg::S_READ: state_next = plic_pkg::S_SCAN;
      plic_pkg::S_SCAN: begin
        if (scan_done && !scan_claim) begin
          state_next = plic_pkg::S_DONE;
        end
      end
      plic_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = plic_pkg::S_IDLE;
        end
      end
      default: state_next = plic_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      pending    <= '0;
      claimed    <= '0;
      scan_claim <= 1'b0;
      scan_vld   <= 1'b0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        thresh[c] <= '0;
      end
    end else begin
      if (state == plic_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
        out_data  <= rdata;
        out_lines <= lines;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (state == plic_pkg::S_IDLE && req.valid) begin
        op_kind  <= dec_kind;
        op_write <= (req.action == plic_pkg::ACT_WRITE);
        op_ctx   <= dec_ctx;
        op_idx   <= dec_idx;
        op_wdata <= req.write_data;
        op_src   <= req.source_id;
        rdata    <= '0;
      end

      if (state == plic_pkg::S_EXEC) begin
        if (op_kind == plic_pkg::OP_REQUEST && src_ok &&
            !pending[src_id] && !claimed[src_id]) begin
          pending[src_id] <= 1'b1;
        end
        if (op_kind == plic_pkg::OP_THRESH) begin
          if (op_write) begin
            thresh[op_ctx] <= op_wdata[P-1:0];
          end else begin
            rdata <= DW'(thresh[op_ctx]);
          end
        end
      end

      if (state == plic_pkg::S_READ && !op_write) begin
        if (op_kind == plic_pkg::OP_PRIO) begin
          rdata <= DW'(prio_rd);
        end else if (op_kind == plic_pkg::OP_ENABLE) begin
          rdata <= en_rd_a;
        end
      end
      // complete: release only a claimed source enabled for this context
      if (state == plic_pkg::S_READ && op_write && op_kind == plic_pkg::OP_CLAIM &&
          cmp_ok && claimed[cmp_id] && en_rd_a[cmp_id[4:0]]) begin
        claimed[cmp_id] <= 1'b0;
      end

      if (scan_done && scan_claim) begin
        rdata <= DW'(best_a_id_next);
        if (best_a_id_next != '0) begin
          pending[best_a_id_next] <= 1'b0;
          claimed[best_a_id_next] <= 1'b1;
        end
      end
      if (scan_done && !scan_claim) begin
        lines <= {(NUM_CONTEXTS > 1) && (best_b_id_next != '0), best_a_id_next != '0};
      end

      if (scan_start) begin
        scan_idx    <= SCAN_W'(1);
        scan_vld    <= 1'b0;
        scan_claim  <= start_claim;
        best_a_id   <= '0;
        best_a_prio <= thresh[start_ctx];
        best_b_id   <= '0;
        best_b_prio <= thresh[CTX_B];
      end else if (state == plic_pkg::S_SCAN) begin
        if (!scan_done) begin
          scan_idx <= scan_idx + 1'b1;
        end
        scan_vld    <= scan_issue;
        scan_id_q   <= ID_W'(scan_idx);
        best_a_id   <= best_a_id_next;
        best_a_prio <= best_a_prio_next;
        best_b_id   <= best_b_id_next;
        best_b_prio <= best_b_prio_next;
      end
    end
  end

  assign req.ready     = (state == plic_pkg::S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.irq_lines = out_lines;

endmodule
